### sv/tlvd_pkg.sv
// Shared types, codes and sizes for the TLV record deframer.
package tlvd_pkg;

  // Known-tag table
  localparam int MAX_TAGS  = 16;
  localparam int TAG_SLOTS = 16;
  localparam int SLOT_W    = 4;

  // Queue between parser and emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic [1:0] KIND_RECORD  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // Buffer end status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_HEADER_FORMAT  = 3'd0;
  localparam logic [2:0] REG_IGNORE_UNKNOWN = 3'd1;
  localparam logic [2:0] REG_TAG_COUNT      = 3'd2;
  localparam logic [2:0] REG_START_OFFSET   = 3'd3;
  localparam logic [2:0] REG_TAG_WORD_0     = 3'd4;
  localparam logic [2:0] REG_TAG_WORD_1     = 3'd5;
  localparam logic [2:0] REG_TAG_WORD_2     = 3'd6;
  localparam logic [2:0] REG_TAG_WORD_3     = 3'd7;

  typedef struct packed {
    logic                         header_format;
    logic                         ignore_unknown;
    logic [4:0]                   tag_count;
    logic [15:0]                  start_offset;
    logic [TAG_SLOTS-1:0][15:0]   tags;
  } cfg_t;

  // One record-start or payload-byte result
  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       record_tag;
    logic [31:0]       record_length;
    logic [7:0]        payload;
    logic              last_of_record;
  } result_t;

  // Everything one input byte causes
  typedef struct packed {
    logic       has_main;
    result_t    main;
    logic       has_status;
    logic [1:0] status;
  } entry_t;

endpackage

### sv/tlvd_ifs.sv
// Channel interfaces: byte stream, result stream and configuration writes.
interface tlvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface tlvd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  slot;
  logic [15:0] record_tag;
  logic [31:0] record_length;
  logic [7:0]  payload;
  logic        last_of_record;
  logic [1:0]  status;
  logic        last_of_run;

  modport source (output valid, kind, slot, record_tag, record_length, payload,
                  last_of_record, status, last_of_run, input ready);
  modport sink   (input valid, kind, slot, record_tag, record_length, payload,
                  last_of_record, status, last_of_run, output ready);
endinterface

interface tlvd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/tlvd_parser.sv
// Front end: takes buffer bytes, tracks header/payload framing, classifies results.
module tlvd_parser (
  input  logic              clk,
  input  logic              rst,
  tlvd_in_if.sink           stream,
  input  tlvd_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              push,
  output tlvd_pkg::entry_t  entry
);
  import tlvd_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_SKIP,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DROP
  } phase_t;

  phase_t            phase, phase_next;
  logic [15:0]       skip_left, skip_left_next;
  logic [2:0]        hdr_seen, hdr_seen_next;
  logic [15:0]       tag_accum, tag_accum_next;
  logic [31:0]       payload_left, payload_left_next;
  logic [SLOT_W-1:0] cur_slot, cur_slot_next;
  logic              discarding, discarding_next;
  logic              error_seen, error_seen_next;
  logic              accept;
  entry_t            ent;

  // First matching slot among the enabled table entries
  function automatic logic [SLOT_W:0] lookup(input cfg_t c, input logic [15:0] tag);
    logic [4:0]        n;
    logic              hit;
    logic [SLOT_W-1:0] s;
    n   = (c.tag_count > 5'(MAX_TAGS)) ? 5'(MAX_TAGS) : c.tag_count;
    hit = 1'b0;
    s   = '0;
    for (int i = MAX_TAGS - 1; i >= 0; i--) begin
      if ((5'(i) < n) && (c.tags[i] == tag)) begin
        hit = 1'b1;
        s   = SLOT_W'(i);
      end
    end
    return {hit, s};
  endfunction

  assign stream.ready = !q_full;
  assign accept       = stream.valid && stream.ready;

  // Per-byte framing step
  always_comb begin
    phase_t            ph;
    logic [15:0]       sl;
    logic [2:0]        hs;
    logic [15:0]       tg;
    logic [31:0]       pl;
    logic [SLOT_W-1:0] cs;
    logic              dc;
    logic              er;
    logic              consumed;
    logic [2:0]        hlen;
    logic [2:0]        tlen;
    logic [SLOT_W:0]   look;
    logic [7:0]        b;

    ph = phase; sl = skip_left; hs = hdr_seen; tg = tag_accum;
    pl = payload_left; cs = cur_slot; dc = discarding; er = error_seen;
    consumed = 1'b0;
    b    = stream.data_byte;
    hlen = cfg.header_format ? 3'd6 : 3'd3;
    tlen = cfg.header_format ? 3'd2 : 3'd1;
    look = '0;
    ent  = '0;

    // buffer start loads the offset
    if (ph == PH_START) begin
      sl = cfg.start_offset;
      hs = 3'd0;
      ph = PH_SKIP;
    end
    if (ph == PH_SKIP) begin
      if (sl != 16'd0) begin
        sl = sl - 16'd1;
        consumed = 1'b1;
      end else begin
        ph = PH_HEADER;
        hs = 3'd0;
      end
    end

    // header bytes, big-endian tag then length
    if (!consumed && ph == PH_HEADER) begin
      if (hs == 3'd0) begin
        tg = 16'd0;
        pl = 32'd0;
      end
      if (hs < tlen) tg = {tg[7:0], b};
      else           pl = {pl[23:0], b};
      hs = hs + 3'd1;
      if (hs >= hlen) begin
        look = lookup(cfg, tg);
        hs   = 3'd0;
        if (look[SLOT_W]) begin
          cs = look[SLOT_W-1:0];
          dc = 1'b0;
          ent.has_main            = 1'b1;
          ent.main.kind           = KIND_RECORD;
          ent.main.slot           = cs;
          ent.main.record_tag     = tg;
          ent.main.record_length  = pl;
          ent.main.last_of_record = (pl == 32'd0);
          ph = (pl != 32'd0) ? PH_PAYLOAD : PH_HEADER;
        end else if (cfg.ignore_unknown) begin
          dc = (pl != 32'd0);
          ph = (pl != 32'd0) ? PH_PAYLOAD : PH_HEADER;
        end else begin
          er = 1'b1;
          ph = PH_DROP;
        end
      end
      consumed = 1'b1;
    end

    // payload bytes
    if (!consumed && ph == PH_PAYLOAD) begin
      pl = pl - 32'd1;
      if (!dc) begin
        ent.has_main            = 1'b1;
        ent.main.kind           = KIND_PAYLOAD;
        ent.main.slot           = cs;
        ent.main.record_tag     = tg;
        ent.main.payload        = b;
        ent.main.last_of_record = (pl == 32'd0);
      end
      if (pl == 32'd0) begin
        ph = PH_HEADER;
        dc = 1'b0;
      end
    end

    // buffer end: report and return to buffer start
    if (stream.end_of_buffer) begin
      ent.has_status = 1'b1;
      if (er)
        ent.status = ST_UNKNOWN;
      else if ((ph == PH_SKIP && sl != 16'd0) || (ph == PH_HEADER && hs != 3'd0) ||
               (ph == PH_PAYLOAD && pl != 32'd0))
        ent.status = ST_TRUNCATED;
      else
        ent.status = ST_OK;
      ph = PH_START; sl = 16'd0; hs = 3'd0; tg = 16'd0;
      pl = 32'd0; cs = '0; dc = 1'b0; er = 1'b0;
    end

    phase_next        = ph;
    skip_left_next    = sl;
    hdr_seen_next     = hs;
    tag_accum_next    = tg;
    payload_left_next = pl;
    cur_slot_next     = cs;
    discarding_next   = dc;
    error_seen_next   = er;
  end

  assign push  = accept && (ent.has_main || ent.has_status);
  assign entry = ent;

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      skip_left    <= '0;
      hdr_seen     <= '0;
      tag_accum    <= '0;
      payload_left <= '0;
      cur_slot     <= '0;
      discarding   <= 1'b0;
      error_seen   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      skip_left    <= skip_left_next;
      hdr_seen     <= hdr_seen_next;
      tag_accum    <= tag_accum_next;
      payload_left <= payload_left_next;
      cur_slot     <= cur_slot_next;
      discarding   <= discarding_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule

### sv/tlvd_queue.sv
// Short entry queue between the parser and the result emitter.
module tlvd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tlvd_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tlvd_pkg::entry_t  head
);
  import tlvd_pkg::*;

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !do_pop)      count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

### sv/tlvd_emitter.sv
// Back end: turns queued entries into single results through an output register.
module tlvd_emitter (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  tlvd_pkg::entry_t  head,
  output logic              pop,
  tlvd_out_if.source        result
);
  import tlvd_pkg::*;

  logic       out_valid;
  result_t    out_res;
  logic [1:0] out_status;
  logic       out_last_run;
  logic       pend;
  logic [1:0] pend_status;
  logic       load;
  result_t    status_res;

  assign load = !out_valid || result.ready;
  assign pop  = load && !pend && head_valid;

  // Result fields of a status: everything zero but the kind
  always_comb begin
    status_res      = '0;
    status_res.kind = KIND_STATUS;
  end

  // Output register; a pending status follows its record or payload result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid    <= 1'b1;
        pend         <= 1'b0;
        out_res      <= status_res;
        out_status   <= pend_status;
        out_last_run <= 1'b1;
      end else if (head_valid) begin
        out_valid <= 1'b1;
        if (head.has_main) begin
          out_res      <= head.main;
          out_status   <= ST_OK;
          out_last_run <= !head.has_status;
          pend         <= head.has_status;
          pend_status  <= head.status;
        end else begin
          out_res      <= status_res;
          out_status   <= head.status;
          out_last_run <= 1'b1;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid          = out_valid;
  assign result.kind           = out_res.kind;
  assign result.slot           = out_res.slot;
  assign result.record_tag     = out_res.record_tag;
  assign result.record_length  = out_res.record_length;
  assign result.payload        = out_res.payload;
  assign result.last_of_record = out_res.last_of_record;
  assign result.status         = out_status;
  assign result.last_of_run    = out_last_run;

endmodule

### sv/tlv_record_deframer.sv
// TLV record deframer: takes one buffer byte per cycle with no stall of its own; the input
// holds back only when the four-entry queue behind the parser is full, which happens only
// under output backpressure. Each byte is framed and its tag matched against the table in
// the cycle it is taken; its results go through the queue and then the output register.
// Results leave at one per cycle while the output is ready; a byte that causes two results
// (a header or last payload byte that is also the buffer's final byte) has its status sent
// second, and the queue absorbs the extra one. Configuration writes are always taken.
module tlv_record_deframer (
  input  logic        clk,
  input  logic        rst,
  tlvd_in_if.sink     stream,
  tlvd_out_if.source  result,
  tlvd_cfg_if.sink    cfg
);
  import tlvd_pkg::*;

  cfg_t   cfg_regs;
  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HEADER_FORMAT:  cfg_regs.header_format  <= cfg.data[0];
        REG_IGNORE_UNKNOWN: cfg_regs.ignore_unknown <= cfg.data[0];
        REG_TAG_COUNT:      cfg_regs.tag_count      <= cfg.data[4:0];
        REG_START_OFFSET:   cfg_regs.start_offset   <= cfg.data[15:0];
        REG_TAG_WORD_0:     cfg_regs.tags[3:0]      <= cfg.data;
        REG_TAG_WORD_1:     cfg_regs.tags[7:4]      <= cfg.data;
        REG_TAG_WORD_2:     cfg_regs.tags[11:8]     <= cfg.data;
        REG_TAG_WORD_3:     cfg_regs.tags[15:12]    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Front end
  tlvd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .cfg    (cfg_regs),
    .q_full (q_full),
    .push   (push),
    .entry  (push_entry)
  );

  // Decoupling queue
  tlvd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end
  tlvd_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

  // A status result always closes the run of its byte
  a_status_closes_run: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind == KIND_STATUS |-> result.last_of_run)
    else $error("status result without last_of_run");

  // Record start is last of record exactly when its length is zero
  a_record_last_len: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind == KIND_RECORD |->
      (result.last_of_record == (result.record_length == 32'd0)))
    else $error("record start last_of_record disagrees with length");

  // The second result of a byte is a status and comes right after the first
  a_status_follows: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && !result.last_of_run |=>
      result.valid && result.kind == KIND_STATUS)
    else $error("missing status after first result of a byte");

endmodule
